FILE: sv/bkst_pkg.sv
// bkst_pkg: shared constants and codes for the bounded key set table.
// Sizes, operation and status codes used by the top level and its assertions.
// Standalone; no dependencies.
`timescale 1ns / 1ps

package bkst_pkg;

  // Pool and field sizes
  localparam int MAX_ENTRIES = 64;
  localparam int KEY_BITS    = 32;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 7;
  localparam int DEF_CAP     = 10;

  // Configuration register map (word index)
  localparam logic REG_CAPACITY = 1'b0;

  // Request operations
  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_REMOVE   = 2'd1;
  localparam logic [1:0] OP_CONTAINS = 2'd2;
  localparam logic [1:0] OP_COUNT    = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_DUP       = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

endpackage

FILE: sv/bounded_key_set_table_unit.sv
// Add, remove and contains scan every slot before their result; read count and an add refused
// as full skip the scan.
// One request at a time: the input stays closed from transfer until the result is handed over;
// a finished result waits in the output register while the next request runs.
// Reset (rst_n, synchronous): valid bits and entry count clear, capacity returns to 10;
// the key store itself is not cleared.
`timescale 1ns / 1ps

module bounded_key_set_table_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] key
  input  logic [1:0]  in_tuser,    // [1:0] operation
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [1:0] status, [2] found, [9:3] entry_count, rest zero
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int MAXN = bkst_pkg::MAX_ENTRIES;
  localparam int IW   = bkst_pkg::IDX_W;
  localparam int CW   = bkst_pkg::CNT_W;
  localparam int KW   = bkst_pkg::KEY_BITS;
  localparam int PW   = bkst_pkg::CAP_W;

  bkst_pkg::state_t state_r, state_nxt;

  logic [PW-1:0]   cap_r;
  logic [MAXN-1:0] slot_valid_r;
  logic [CW-1:0]   held_count_r, held_count_nxt;

  logic [1:0]      op_r;
  logic [KW-1:0]   key_r;

  logic [IW:0]     rd_idx_r;
  logic [KW-1:0]   rd_data_r;
  logic [IW-1:0]   cmp_idx_r;
  logic            cmp_vld_r;

  logic            hit_r;
  logic [IW-1:0]   hit_idx_r;
  logic            free_seen_r;
  logic [IW-1:0]   free_idx_r;

  logic            out_tvalid_r;
  logic [1:0]      out_status_r;
  logic            out_found_r;
  logic [CW-1:0]   out_count_r;

  logic [KW-1:0]   slot_key_mem [MAXN];

  logic            in_xfer;
  logic            cfg_wr;
  logic            out_free;
  logic            fin_go;
  logic [CW-1:0]   cap_eff;
  logic            is_full;
  logic            scan_done;
  logic [1:0]      res_status;
  logic            res_found;
  logic            do_insert;
  logic            do_delete;

  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign fin_go    = (state_r == bkst_pkg::S_FIN) && out_free;
  assign scan_done = (rd_idx_r == (IW+1)'(MAXN)) && !cmp_vld_r;

  // Configuration port: always ready, one register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == bkst_pkg::REG_CAPACITY) ? 32'(cap_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= PW'(bkst_pkg::DEF_CAP);
    end else if (cfg_wr && cfg_paddr[2] == bkst_pkg::REG_CAPACITY) begin
      cap_r <= cfg_pwdata[PW-1:0];
    end
  end

  // Effective capacity: zero means default, clamp to pool size
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CW'(bkst_pkg::DEF_CAP);
    end else if (32'(cap_r) > 32'(MAXN)) begin
      cap_eff = CW'(MAXN);
    end else begin
      cap_eff = CW'(cap_r);
    end
  end

  assign is_full = 32'(held_count_r) >= 32'(cap_eff);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bkst_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (in_tuser == bkst_pkg::OP_COUNT || (in_tuser == bkst_pkg::OP_ADD && is_full)) begin
            state_nxt = bkst_pkg::S_FIN;
          end else begin
            state_nxt = bkst_pkg::S_SCAN;
          end
        end
      end
      bkst_pkg::S_SCAN: begin
        if (scan_done) state_nxt = bkst_pkg::S_FIN;
      end
      bkst_pkg::S_FIN: begin
        if (out_free) state_nxt = bkst_pkg::S_IDLE;
      end
      default: state_nxt = bkst_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= bkst_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_tready = (state_r == bkst_pkg::S_IDLE);

  // Capture the request
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r  <= in_tuser;
      key_r <= in_tdata[KW-1:0];
    end
  end

  // Scan address counter: one slot per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        rd_idx_r <= '0;
      end else if (state_r == bkst_pkg::S_SCAN && rd_idx_r != (IW+1)'(MAXN)) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      cmp_vld_r <= (state_r == bkst_pkg::S_SCAN) && (rd_idx_r != (IW+1)'(MAXN));
    end
  end

  // Key store: one registered read port for the scan, one write port for inserts
  always_ff @(posedge clk) begin
    rd_data_r <= slot_key_mem[rd_idx_r[IW-1:0]];
    cmp_idx_r <= rd_idx_r[IW-1:0];
    if (do_insert) slot_key_mem[free_idx_r] <= key_r;
  end

  // Shared compare unit: first match and lowest free slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r       <= 1'b0;
      free_seen_r <= 1'b0;
    end else if (in_xfer) begin
      hit_r       <= 1'b0;
      free_seen_r <= 1'b0;
    end else if (cmp_vld_r) begin
      if (slot_valid_r[cmp_idx_r] && rd_data_r == key_r && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= cmp_idx_r;
      end
      if (!slot_valid_r[cmp_idx_r] && !free_seen_r) begin
        free_seen_r <= 1'b1;
        free_idx_r  <= cmp_idx_r;
      end
    end
  end

  // Result and write-back decision
  always_comb begin
    res_status     = bkst_pkg::ST_OK;
    res_found      = 1'b0;
    do_insert      = 1'b0;
    do_delete      = 1'b0;
    held_count_nxt = held_count_r;
    case (op_r)
      bkst_pkg::OP_ADD: begin
        if (is_full) begin
          res_status = bkst_pkg::ST_FULL;
        end else if (hit_r) begin
          res_status = bkst_pkg::ST_DUP;
        end else if (free_seen_r) begin
          do_insert      = fin_go;
          held_count_nxt = held_count_r + 1'b1;
        end else begin
          res_status = bkst_pkg::ST_FULL;
        end
      end
      bkst_pkg::OP_REMOVE: begin
        if (hit_r) begin
          do_delete = fin_go;
          if (held_count_r != '0) held_count_nxt = held_count_r - 1'b1;
        end else begin
          res_status = bkst_pkg::ST_NOT_FOUND;
        end
      end
      bkst_pkg::OP_CONTAINS: res_found = hit_r;
      default: ;
    endcase
  end

  // Commit valid bits and count when the result is handed over
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      held_count_r <= '0;
    end else if (fin_go) begin
      held_count_r <= held_count_nxt;
      if (do_insert) slot_valid_r[free_idx_r] <= 1'b1;
      if (do_delete) slot_valid_r[hit_idx_r]  <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (fin_go) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_status_r <= res_status;
      out_found_r  <= res_found;
      out_count_r  <= held_count_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = 16'({out_count_r, out_found_r, out_status_r});

`ifndef SYNTHESIS
  // Valid bits and entry count stay in step
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(slot_valid_r) == 32'(held_count_r))
    else $error("entry count differs from number of valid slots");

  // Count never exceeds the pool
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(held_count_r) <= 32'(MAXN))
    else $error("entry count above pool size");

  // A request transfer closes the input until its result is produced
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("input ready right after a request transfer");

  // An add that stores a key raises the count by one
  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && do_insert) |=> held_count_r == $past(held_count_r) + 1'b1)
    else $error("insert did not advance the count");
`endif

endmodule

FILE: tb/sv/tb_bounded_key_set_table_unit.sv
// Self-checking testbench for bounded_key_set_table_unit: add, remove, contains and count
// requests over the stream ports, capacity set over the APB port, results scored in order.
// Depends on bkst_pkg and the bounded_key_set_table_unit RTL.
`timescale 1ns / 1ps

module tb_bounded_key_set_table_unit;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 70;
  localparam int KEY_POOL_SIZE  = 80;
  localparam int NUM_PHASES     = 7;

  typedef struct packed {
    logic [1:0]                 status;
    logic                       found;
    logic [bkst_pkg::CNT_W-1:0] count;
  } outcome_t;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] key;
    bit          typed;
    outcome_t    result;
  } req_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;    // [31:0] key
  logic [1:0]  in_tuser = '0;    // [1:0] operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // [1:0] status, [2] found, [9:3] entry_count, rest zero
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Shadow copy of the table contents and the capacity register
  logic [bkst_pkg::KEY_BITS-1:0] shadow_key [bkst_pkg::MAX_ENTRIES];
  bit                            shadow_valid [bkst_pkg::MAX_ENTRIES];
  int                            shadow_count = 0;
  logic [bkst_pkg::CAP_W-1:0]    shadow_cap = bkst_pkg::CAP_W'(bkst_pkg::DEF_CAP);

  outcome_t    pending_outcomes [$];
  req_row_t    directed_rows [$];
  logic [31:0] key_pool [KEY_POOL_SIZE];
  int          err_count = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  bit          calm = 1'b0;

  bounded_key_set_table_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Apply one request to the shadow table and return the result it produces
  function automatic outcome_t table_outcome(input logic [1:0] op, input logic [31:0] key);
    outcome_t res;
    int limit;
    int hit;
    limit = (shadow_cap == 0) ? bkst_pkg::DEF_CAP : int'(shadow_cap);
    if (limit > bkst_pkg::MAX_ENTRIES) limit = bkst_pkg::MAX_ENTRIES;
    hit = -1;
    for (int i = bkst_pkg::MAX_ENTRIES - 1; i >= 0; i--) begin
      if (shadow_valid[i] && shadow_key[i] == key[bkst_pkg::KEY_BITS-1:0]) hit = i;
    end
    res = '0;
    res.status = bkst_pkg::ST_OK;
    case (op)
      bkst_pkg::OP_ADD: begin
        if (shadow_count >= limit) begin
          res.status = bkst_pkg::ST_FULL;
        end else if (hit >= 0) begin
          res.status = bkst_pkg::ST_DUP;
        end else begin
          res.status = bkst_pkg::ST_FULL;
          for (int i = 0; i < bkst_pkg::MAX_ENTRIES; i++) begin
            if (!shadow_valid[i] && res.status == bkst_pkg::ST_FULL) begin
              shadow_valid[i] = 1'b1;
              shadow_key[i] = key[bkst_pkg::KEY_BITS-1:0];
              shadow_count++;
              res.status = bkst_pkg::ST_OK;
            end
          end
        end
      end
      bkst_pkg::OP_REMOVE: begin
        if (hit >= 0) begin
          shadow_valid[hit] = 1'b0;
          if (shadow_count > 0) shadow_count--;
        end else begin
          res.status = bkst_pkg::ST_NOT_FOUND;
        end
      end
      bkst_pkg::OP_CONTAINS: res.found = (hit >= 0);
      default: ;
    endcase
    res.count = bkst_pkg::CNT_W'(shadow_count);
    return res;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Present one request, hold it until transferred, then queue its result
  task automatic send_request(input logic [1:0] op, input logic [31:0] key,
                              input bit typed, input outcome_t typed_out);
    int gap;
    outcome_t predicted;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= key;
    in_tuser <= op;
    do @(posedge clk); while (!in_tready);
    predicted = table_outcome(op, key);
    pending_outcomes.push_back(typed ? typed_out : predicted);
  endtask

  // Drop valid and hold off until every queued result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access until pready
  task automatic cfg_transfer(input bit is_write, input logic [31:0] wdata,
                              output logic [31:0] rdata);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= is_write;
    cfg_paddr <= {bkst_pkg::REG_CAPACITY, 2'b00};
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic check_capacity_reg();
    logic [31:0] rd;
    cfg_transfer(1'b0, '0, rd);
    if (rd !== 32'(shadow_cap)) begin
      $error("capacity_limit: expected %0d, got %0d", shadow_cap, rd);
      err_count++;
    end
  endtask

  // Write the capacity register on an idle table and read it back
  task automatic program_capacity(input logic [31:0] value);
    logic [31:0] rd;
    drain_results();
    cfg_transfer(1'b1, value, rd);
    shadow_cap = value[bkst_pkg::CAP_W-1:0];
    check_capacity_reg();
  endtask

  task automatic put_row(input logic [1:0] op, input logic [31:0] key, input bit typed,
                         input logic [1:0] st, input logic fnd, input int cnt);
    req_row_t row;
    row.op = op;
    row.key = key;
    row.typed = typed;
    row.result = '{status: st, found: fnd, count: bkst_pkg::CNT_W'(cnt)};
    directed_rows.push_back(row);
  endtask

  // Clear the shadow table and release reset
  initial begin
    for (int i = 0; i < bkst_pkg::MAX_ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Receiver: random stalls, none started while calm
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 20) begin
      out_tready <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Score each result transfer against the oldest expectation
  always @(posedge clk) begin
    outcome_t exp_out;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_outcomes.size() == 0) begin
        $error("result transfer with no request outstanding: tdata %h", out_tdata);
        err_count++;
      end else begin
        exp_out = pending_outcomes.pop_front();
        if (out_tdata[1:0] !== exp_out.status) begin
          $error("status: expected %0d, got %0d", exp_out.status, out_tdata[1:0]);
          err_count++;
        end
        if (out_tdata[2] !== exp_out.found) begin
          $error("found: expected %0d, got %0d", exp_out.found, out_tdata[2]);
          err_count++;
        end
        if (out_tdata[9:3] !== exp_out.count) begin
          $error("entry_count: expected %0d, got %0d", exp_out.count, out_tdata[9:3]);
          err_count++;
        end
        if (out_tdata[15:10] !== '0) begin
          $error("padding: expected 0, got %h", out_tdata[15:10]);
          err_count++;
        end
      end
    end
  end

  // Watchdog: end the run after too many cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_bounded_key_set_table_unit failed");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int phase_cap [NUM_PHASES];
    int phase_items [NUM_PHASES];
    int phase_add [NUM_PHASES];
    int phase_rem [NUM_PHASES];
    int r;
    logic [1:0] op;
    logic [31:0] key;

    phase_cap = '{3, 0, 1, 64, 127, 2, -1};
    phase_items = '{60, 200, 100, 400, 200, 150, 240};
    phase_add = '{30, 50, 45, 70, 60, 40, 50};
    phase_rem = '{40, 25, 30, 15, 25, 40, 30};

    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom();

    // Directed rows at the reset capacity of ten
    put_row(bkst_pkg::OP_COUNT,    32'h0000_0000, 1'b1, bkst_pkg::ST_OK,        1'b0, 0);
    put_row(bkst_pkg::OP_CONTAINS, 32'h0000_0000, 1'b1, bkst_pkg::ST_OK,        1'b0, 0);
    put_row(bkst_pkg::OP_REMOVE,   32'hFFFF_FFFF, 1'b1, bkst_pkg::ST_NOT_FOUND, 1'b0, 0);
    put_row(bkst_pkg::OP_ADD,      32'h0000_0000, 1'b1, bkst_pkg::ST_OK,        1'b0, 1);
    put_row(bkst_pkg::OP_ADD,      32'h0000_0000, 1'b1, bkst_pkg::ST_DUP,       1'b0, 1);
    put_row(bkst_pkg::OP_ADD,      32'hFFFF_FFFF, 1'b1, bkst_pkg::ST_OK,        1'b0, 2);
    put_row(bkst_pkg::OP_CONTAINS, 32'hFFFF_FFFF, 1'b1, bkst_pkg::ST_OK,        1'b1, 2);
    put_row(bkst_pkg::OP_CONTAINS, 32'h7FFF_FFFF, 1'b1, bkst_pkg::ST_OK,        1'b0, 2);
    put_row(bkst_pkg::OP_ADD,      32'h8000_0000, 1'b1, bkst_pkg::ST_OK,        1'b0, 3);
    for (int k = 1; k <= 7; k++) begin
      put_row(bkst_pkg::OP_ADD, 32'(k), 1'b1, bkst_pkg::ST_OK, 1'b0, 3 + k);
    end
    // Table full, then full with a duplicate key
    put_row(bkst_pkg::OP_ADD,      32'h5555_5555, 1'b1, bkst_pkg::ST_FULL,      1'b0, 10);
    put_row(bkst_pkg::OP_ADD,      32'h0000_0000, 1'b1, bkst_pkg::ST_FULL,      1'b0, 10);
    put_row(bkst_pkg::OP_REMOVE,   32'h0000_0000, 1'b1, bkst_pkg::ST_OK,        1'b0, 9);
    put_row(bkst_pkg::OP_ADD,      32'hAAAA_AAAA, 1'b0, bkst_pkg::ST_OK,        1'b0, 0);
    put_row(bkst_pkg::OP_CONTAINS, 32'hAAAA_AAAA, 1'b0, bkst_pkg::ST_OK,        1'b0, 0);
    put_row(bkst_pkg::OP_REMOVE,   32'hAAAA_AAAA, 1'b0, bkst_pkg::ST_OK,        1'b0, 0);
    put_row(bkst_pkg::OP_COUNT,    32'h1234_5678, 1'b0, bkst_pkg::ST_OK,        1'b0, 0);

    @(posedge clk);
    while (!rst_n) @(posedge clk);
    check_capacity_reg();

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].typed,
                   directed_rows[i].result);
    end

    // Random phases, each at its own capacity; the first one sits below the count
    for (int p = 0; p < NUM_PHASES; p++) begin
      program_capacity((phase_cap[p] < 0) ? $urandom_range(0, 64) : phase_cap[p]);
      for (int n = 0; n < phase_items[p]; n++) begin
        if ($urandom_range(0, 63) == 0) calm = !calm;
        if (p == 1 && n == 100) drain_results();
        r = $urandom_range(0, 99);
        if (r < phase_add[p]) begin
          op = bkst_pkg::OP_ADD;
        end else if (r < phase_add[p] + phase_rem[p]) begin
          op = bkst_pkg::OP_REMOVE;
        end else begin
          op = ($urandom_range(0, 9) < 7) ? bkst_pkg::OP_CONTAINS : bkst_pkg::OP_COUNT;
        end
        key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)]
                                           : $urandom();
        send_request(op, key, 1'b0, '0);
      end
    end

    // Wait out the remaining results, then a little longer for strays
    in_tvalid <= 1'b0;
    calm = 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_bounded_key_set_table_unit passed");
    end else begin
      $display("tb_bounded_key_set_table_unit failed");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/bkst_pkg.sv
sv/bounded_key_set_table_unit.sv
tb/sv/tb_bounded_key_set_table_unit.sv
